### rtl/core/brf_pkg.sv
// brf_pkg: shared constants, types and index arithmetic for the byte ring FIFO.
// No dependencies; imported by every module under rtl/core.
package brf_pkg;

	localparam int MAX_DEPTH = 4096;
	localparam int MAX_BURST = 64;
	localparam int MIN_CAP   = 2;
	localparam int CAP_RESET = 4096;

	localparam int IDX_W   = $clog2(MAX_DEPTH);
	localparam int CAP_W   = IDX_W + 1;
	localparam int BURST_W = $clog2(MAX_BURST + 1);
	localparam int KIND_W  = 3;
	localparam int BYTE_W  = 8;

	localparam int CQ_DEPTH = 4;
	localparam int OQ_DEPTH = 4;

	localparam int APB_AW = 2;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-1:0] ADDR_CAPACITY = 2'd0;

	localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_READ    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SKIP    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ADVANCE = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd5;

	typedef enum logic [2:0] {
		OP_WRITE,
		OP_READ,
		OP_PEEK,
		OP_SKIP,
		OP_ADV,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef enum logic {
		BK_IDLE,
		BK_BURST
	} back_state_t;

	typedef struct packed {
		op_t                op;
		logic [BYTE_W-1:0]  data;
		logic [BURST_W-1:0] burst;
		logic [IDX_W-1:0]   amt;
	} cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  out_byte;
		logic               byte_valid;
		logic               last;
		logic [BURST_W-1:0] moved;
		logic [IDX_W-1:0]   used;
		logic [IDX_W-1:0]   free;
	} res_t;

	function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] idx,
		input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] v;
		v = {1'b0, idx} + CAP_W'(1);
		return (v == cap) ? '0 : v[IDX_W-1:0];
	endfunction

	// amt is already saturated to cap - 1, so one subtract wraps it
	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
		input logic [IDX_W-1:0] amt, input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] v;
		v = {1'b0, idx} + {1'b0, amt};
		if (v >= cap)
			v = v - cap;
		return v[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] used_of(input logic [IDX_W-1:0] w,
		input logic [IDX_W-1:0] r, input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] d;
		if (w >= r)
			d = {1'b0, w} - {1'b0, r};
		else
			d = cap - ({1'b0, r} - {1'b0, w});
		return d[IDX_W-1:0];
	endfunction

endpackage

### rtl/core/byte_ring_fifo_top.sv
// byte_ring_fifo_top: APB capacity register, front decoder, back sequencer and
// result queue of the byte ring FIFO. Uses brf_pkg, brf_front, brf_back, brf_outq.
// An item goes through the command queue, the back read stage and the result queue.
// One item per cycle while not full; a read or peek of n bytes holds the back end
// for all n bytes, one byte per cycle while the result queue has room, from the single read port of the byte store.
// Reset: indices cleared, capacity 4096, queues empty; no clearing pass.
module byte_ring_fifo_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [brf_pkg::APB_AW-1:0]  paddr,
	input  logic [brf_pkg::APB_DW-1:0]  pwdata,
	output logic [brf_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        push,
	output logic                        full,
	input  logic [brf_pkg::KIND_W-1:0]  kind,
	input  logic [brf_pkg::BYTE_W-1:0]  data_byte,
	input  logic [brf_pkg::BURST_W-1:0] burst_length,
	input  logic [brf_pkg::IDX_W-1:0]   move_amount,
	output logic                        empty,
	input  logic                        pop,
	output logic [brf_pkg::BYTE_W-1:0]  out_byte,
	output logic                        byte_valid,
	output logic                        last,
	output logic [brf_pkg::BURST_W-1:0] moved_count,
	output logic [brf_pkg::IDX_W-1:0]   used_count,
	output logic [brf_pkg::IDX_W-1:0]   free_count
);
	import brf_pkg::*;

	logic [CAP_W-1:0] cap_raw_q, cap_q, cap_eff;
	logic             cfg_wr;
	logic             cmd_valid, cmd_pop, room, res_push;
	cmd_t             cmd;
	res_t             res, head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY);
	assign prdata = (paddr == ADDR_CAPACITY) ? APB_DW'(cap_raw_q) : '0;

	always_comb begin
		cap_eff = pwdata[CAP_W-1:0];
		if (cap_eff < CAP_W'(MIN_CAP))
			cap_eff = CAP_W'(MIN_CAP);
		else if (cap_eff > CAP_W'(MAX_DEPTH))
			cap_eff = CAP_W'(MAX_DEPTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_raw_q <= CAP_W'(CAP_RESET);
			cap_q     <= CAP_W'(CAP_RESET);
		end else if (cfg_wr) begin
			cap_raw_q <= pwdata[CAP_W-1:0];
			cap_q     <= cap_eff;
		end
	end

	brf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.data_byte    (data_byte),
		.burst_length (burst_length),
		.move_amount  (move_amount),
		.cap          (cap_q),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	brf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap       (cap_q),
		.cfg_clear (cfg_wr),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.room      (room),
		.res_push  (res_push),
		.res       (res)
	);

	brf_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res),
		.room     (room),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	assign out_byte    = head.out_byte;
	assign byte_valid  = head.byte_valid;
	assign last        = head.last;
	assign moved_count = head.moved;
	assign used_count  = head.used;
	assign free_count  = head.free;

endmodule

### rtl/core/brf_front.sv
// brf_front: accepts input items, decodes the kind, clamps burst and move
// amount, and queues decoded commands for the back end. Uses brf_pkg.
module brf_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [brf_pkg::KIND_W-1:0]  kind,
	input  logic [brf_pkg::BYTE_W-1:0]  data_byte,
	input  logic [brf_pkg::BURST_W-1:0] burst_length,
	input  logic [brf_pkg::IDX_W-1:0]   move_amount,
	input  logic [brf_pkg::CAP_W-1:0]   cap,
	output logic                        cmd_valid,
	output brf_pkg::cmd_t               cmd,
	input  logic                        cmd_pop
);
	import brf_pkg::*;

	localparam int PTR_W = $clog2(CQ_DEPTH);
	localparam int CNT_W = $clog2(CQ_DEPTH + 1);

	cmd_t             ent_q [CQ_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;
	cmd_t             dec;
	logic [CAP_W-1:0] cap_m1;
	logic             do_push, do_pop;

	assign cap_m1 = cap - CAP_W'(1);

	always_comb begin
		dec.data  = data_byte;
		dec.burst = (burst_length > BURST_W'(MAX_BURST)) ? BURST_W'(MAX_BURST) : burst_length;
		dec.amt   = ({1'b0, move_amount} > cap_m1) ? cap_m1[IDX_W-1:0] : move_amount;
		case (kind)
			KIND_WRITE:   dec.op = OP_WRITE;
			KIND_READ:    dec.op = OP_READ;
			KIND_PEEK:    dec.op = OP_PEEK;
			KIND_SKIP:    dec.op = OP_SKIP;
			KIND_ADVANCE: dec.op = OP_ADV;
			KIND_CLEAR:   dec.op = OP_CLEAR;
			default:      dec.op = OP_NOP;
		endcase
	end

	assign full      = (cnt_q == CNT_W'(CQ_DEPTH));
	assign do_push   = push && !full;
	assign cmd_valid = (cnt_q != '0);
	assign do_pop    = cmd_pop && cmd_valid;
	assign cmd       = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			ent_q[wptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push)
				wptr_q <= wptr_q + PTR_W'(1);
			if (do_pop)
				rptr_q <= rptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

### rtl/core/brf_outq.sv
// brf_outq: small result queue in front of the output ports; reports room
// for one more in-flight result. Uses brf_pkg.
module brf_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_push,
	input  brf_pkg::res_t res_in,
	output logic          room,
	input  logic          pop,
	output logic          empty,
	output brf_pkg::res_t head
);
	import brf_pkg::*;

	localparam int PTR_W = $clog2(OQ_DEPTH);
	localparam int CNT_W = $clog2(OQ_DEPTH + 1);

	res_t             ent_q [OQ_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign empty  = (cnt_q == '0);
	assign do_pop = pop && !empty;
	assign head   = ent_q[rptr_q];
	// keep a slot for the beat already in the read stage
	assign room   = (cnt_q <= CNT_W'(OQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (res_push)
			ent_q[wptr_q] <= res_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (res_push)
				wptr_q <= wptr_q + PTR_W'(1);
			if (do_pop)
				rptr_q <= rptr_q + PTR_W'(1);
			if (res_push && !do_pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !res_push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (cnt_q != CNT_W'(OQ_DEPTH)))
		else $error("result queue overflow");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(OQ_DEPTH))
		else $error("result queue count out of range");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(wptr_q - rptr_q) == cnt_q[PTR_W-1:0])
		else $error("result queue pointers disagree with count");

endmodule

### rtl/core/brf_back.sv
// brf_back: ring indices, byte store and burst sequencer; one result beat per
// cycle while the result queue has room, through a registered read stage. Uses brf_pkg.
module brf_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [brf_pkg::CAP_W-1:0] cap,
	input  logic                      cfg_clear,
	input  logic                      cmd_valid,
	input  brf_pkg::cmd_t             cmd,
	output logic                      cmd_pop,
	input  logic                      room,
	output logic                      res_push,
	output brf_pkg::res_t             res
);
	import brf_pkg::*;

	logic [BYTE_W-1:0]  mem [MAX_DEPTH];

	back_state_t        state_q, state_d;
	logic [IDX_W-1:0]   rd_q, rd_d, wr_q, wr_d, pos_q, pos_d;
	logic [BURST_W-1:0] moved_q, moved_d, n_q, n_d;
	logic               peek_q, peek_d;

	logic [IDX_W-1:0]   used_now, rd_addr;
	logic [CAP_W-1:0]   free_full;
	logic [BURST_W-1:0] n_clip, moved_nx;
	logic               mem_we, issue;
	logic               bv_nx, last_nx;

	logic               valid_s1, bv_s1, last_s1;
	logic [BURST_W-1:0] moved_s1;
	logic [BYTE_W-1:0]  mem_rd_s1;

	// indices already reflect every beat that has reached the read stage
	assign used_now  = used_of(wr_q, rd_q, cap);
	assign free_full = cap - CAP_W'(1) - {1'b0, used_now};
	assign n_clip    = (IDX_W'(cmd.burst) > used_now) ? used_now[BURST_W-1:0] : cmd.burst;
	assign moved_nx  = moved_q + BURST_W'(1);

	always_comb begin
		state_d = state_q;
		rd_d    = rd_q;
		wr_d    = wr_q;
		pos_d   = pos_q;
		moved_d = moved_q;
		n_d     = n_q;
		peek_d  = peek_q;
		cmd_pop = 1'b0;
		mem_we  = 1'b0;
		issue   = 1'b0;
		bv_nx   = 1'b0;
		last_nx = 1'b1;
		res.moved = '0;
		rd_addr = pos_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && room) begin
					cmd_pop = 1'b1;
					issue   = 1'b1;
					case (cmd.op)
						OP_WRITE: begin
							if ({1'b0, used_now} != cap - CAP_W'(1)) begin
								mem_we    = 1'b1;
								wr_d      = inc_wrap(wr_q, cap);
								res.moved = BURST_W'(1);
							end
						end
						OP_READ, OP_PEEK: begin
							if (n_clip != '0) begin
								rd_addr   = rd_q;
								bv_nx     = 1'b1;
								res.moved = BURST_W'(1);
								last_nx   = (n_clip == BURST_W'(1));
								if (cmd.op == OP_READ)
									rd_d = inc_wrap(rd_q, cap);
								if (n_clip != BURST_W'(1)) begin
									state_d = BK_BURST;
									pos_d   = inc_wrap(rd_q, cap);
									moved_d = BURST_W'(1);
									n_d     = n_clip;
									peek_d  = (cmd.op == OP_PEEK);
								end
							end
						end
						OP_SKIP:  rd_d = wrap_add(rd_q, cmd.amt, cap);
						OP_ADV:   wr_d = wrap_add(wr_q, cmd.amt, cap);
						OP_CLEAR: begin
							rd_d = '0;
							wr_d = '0;
						end
						default: ;
					endcase
				end
			end
			BK_BURST: begin
				if (room) begin
					issue     = 1'b1;
					bv_nx     = 1'b1;
					res.moved = moved_nx;
					last_nx   = (moved_nx == n_q);
					pos_d     = inc_wrap(pos_q, cap);
					moved_d   = moved_nx;
					if (!peek_q)
						rd_d = inc_wrap(pos_q, cap);
					if (moved_nx == n_q)
						state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
		if (cfg_clear) begin
			rd_d = '0;
			wr_d = '0;
		end
		// the read stage drives the outgoing beat; used and free come from the current indices
		res.moved      = moved_s1;
		res.out_byte   = bv_s1 ? mem_rd_s1 : '0;
		res.byte_valid = bv_s1;
		res.last       = last_s1;
		res.used       = used_now;
		res.free       = free_full[IDX_W-1:0];
	end

	assign res_push = valid_s1;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_q] <= cmd.data;
		mem_rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		bv_s1    <= bv_nx;
		last_s1  <= last_nx;
		moved_s1 <= bv_nx ? (state_q == BK_BURST ? moved_nx : BURST_W'(1))
			: ((state_q == BK_IDLE && cmd.op == OP_WRITE && mem_we) ? BURST_W'(1) : '0);
		pos_q    <= pos_d;
		moved_q  <= moved_d;
		n_q      <= n_d;
		peek_q   <= peek_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			rd_q     <= '0;
			wr_q     <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_q     <= rd_d;
			wr_q     <= wr_d;
			valid_s1 <= issue;
		end
	end

	a_rd_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, rd_q} < cap)
		else $error("read index outside ring");

	a_wr_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, wr_q} < cap)
		else $error("write index outside ring");

	a_burst_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_BURST) |-> (moved_q < n_q && n_q <= BURST_W'(MAX_BURST)))
		else $error("burst counter past its length");

endmodule

### sim/byte_ring_fifo_top_tb.sv
// byte_ring_fifo_top_tb: self-checking bench for the byte ring FIFO top level.
// Drives items and capacity writes and checks every result beat against a ring model.
// Depends on brf_pkg and byte_ring_fifo_top.
module byte_ring_fifo_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import brf_pkg::*;

	// kinds past clear are unused codes; the block must treat them as no-ops
	localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;
	localparam int NUM_SEGS = 10;
	localparam int RAND_PER_SEG = 35;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic [BYTE_W-1:0]  data;
		logic [BURST_W-1:0] burst;
		logic [IDX_W-1:0]   amt;
	} ring_cmd_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                push = 1'b0;
	logic                full;
	logic [KIND_W-1:0]   kind = '0;
	logic [BYTE_W-1:0]   data_byte = '0;
	logic [BURST_W-1:0]  burst_length = '0;
	logic [IDX_W-1:0]    move_amount = '0;
	logic                empty;
	logic                pop = 1'b0;
	logic [BYTE_W-1:0]   out_byte;
	logic                byte_valid;
	logic                last;
	logic [BURST_W-1:0]  moved_count;
	logic [IDX_W-1:0]    used_count;
	logic [IDX_W-1:0]    free_count;

	ring_cmd_t todo_cmds [$];
	res_t      due_results [$];
	int        errors = 0;
	int        send_idle_pct = 10;
	int        recv_idle_pct = 76;
	int        cap_plan [NUM_SEGS] = '{4096, 0, 5, 4096, 1, 8191, 37, 4097, 3, 200};

	// ring model state
	logic [BYTE_W-1:0] ring_mem [MAX_DEPTH];
	bit                written [MAX_DEPTH];
	int                rd_idx = 0;
	int                wr_idx = 0;
	logic [CAP_W-1:0]  cap_reg = CAP_W'(CAP_RESET);

	byte_ring_fifo_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full), .kind(kind), .data_byte(data_byte),
		.burst_length(burst_length), .move_amount(move_amount),
		.empty(empty), .pop(pop), .out_byte(out_byte), .byte_valid(byte_valid),
		.last(last), .moved_count(moved_count), .used_count(used_count),
		.free_count(free_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_cap();
		int c;
		c = cap_reg;
		if (c < MIN_CAP)
			c = MIN_CAP;
		if (c > MAX_DEPTH)
			c = MAX_DEPTH;
		return c;
	endfunction

	function automatic int held(int cap);
		if (wr_idx >= rd_idx)
			return wr_idx - rd_idx;
		return cap - (rd_idx - wr_idx);
	endfunction

	// single wrap; amounts of cap or more saturate to cap - 1
	function automatic int ring_add(int idx, int amt, int cap);
		int v;
		if (amt > cap - 1)
			amt = cap - 1;
		v = idx + amt;
		if (v >= cap)
			v -= cap;
		return v;
	endfunction

	function automatic void post_beat(int b, bit v, bit l, int moved, int cap);
		res_t r;
		int u;
		u = held(cap);
		r.out_byte = BYTE_W'(b);
		r.byte_valid = v;
		r.last = l;
		r.moved = BURST_W'(moved);
		r.used = IDX_W'(u);
		r.free = IDX_W'(cap - 1 - u);
		due_results.push_back(r);
	endfunction

	function automatic void ring_apply(ring_cmd_t c);
		int cap, u, n, pos;
		cap = eff_cap();
		if (rd_idx >= cap)
			rd_idx = 0;
		if (wr_idx >= cap)
			wr_idx = 0;
		u = held(cap);
		case (c.kind)
			KIND_WRITE: begin
				if (cap - 1 - u == 0) begin
					post_beat(0, 1'b0, 1'b1, 0, cap);
				end else begin
					ring_mem[wr_idx] = c.data;
					written[wr_idx] = 1'b1;
					wr_idx = ring_add(wr_idx, 1, cap);
					post_beat(0, 1'b0, 1'b1, 1, cap);
				end
			end
			KIND_READ, KIND_PEEK: begin
				n = c.burst;
				if (n > MAX_BURST)
					n = MAX_BURST;
				if (n > u)
					n = u;
				if (n == 0)
					post_beat(0, 1'b0, 1'b1, 0, cap);
				pos = rd_idx;
				for (int k = 0; k < n; k++) begin
					int b;
					b = ring_mem[pos];
					pos = ring_add(pos, 1, cap);
					if (c.kind == KIND_READ)
						rd_idx = pos;
					post_beat(b, 1'b1, k + 1 == n, k + 1, cap);
				end
			end
			KIND_SKIP: begin
				rd_idx = ring_add(rd_idx, c.amt, cap);
				post_beat(0, 1'b0, 1'b1, 0, cap);
			end
			KIND_ADVANCE: begin
				wr_idx = ring_add(wr_idx, c.amt, cap);
				post_beat(0, 1'b0, 1'b1, 0, cap);
			end
			KIND_CLEAR: begin
				rd_idx = 0;
				wr_idx = 0;
				post_beat(0, 1'b0, 1'b1, 0, cap);
			end
			default: post_beat(0, 1'b0, 1'b1, 0, cap);
		endcase
	endfunction

	// shorten a read so it never touches a slot that was never written
	function automatic int safe_burst(int want);
		int cap, n, k, pos;
		cap = eff_cap();
		n = (want > MAX_BURST) ? MAX_BURST : want;
		if (n > held(cap))
			n = held(cap);
		pos = rd_idx;
		k = 0;
		while (k < n && written[pos]) begin
			k++;
			pos = ring_add(pos, 1, cap);
		end
		return (k == n) ? want : k;
	endfunction

	function automatic void add_cmd(logic [KIND_W-1:0] k, int d, int b, int a);
		ring_cmd_t c;
		c.kind = k;
		c.data = BYTE_W'(d);
		c.burst = BURST_W'(b);
		c.amt = IDX_W'(a);
		if (k == KIND_READ || k == KIND_PEEK)
			c.burst = BURST_W'(safe_burst(b));
		ring_apply(c);
		todo_cmds.push_back(c);
	endfunction

	function automatic void add_random_cmd();
		int cap, u, r, b, a;
		logic [KIND_W-1:0] k;
		cap = eff_cap();
		u = held(cap);
		r = $urandom_range(0, 99);
		b = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 16);
		a = $urandom_range(0, 4095);
		if (r < 45) begin
			k = KIND_WRITE;
		end else if (r < 63) begin
			k = KIND_READ;
		end else if (r < 72) begin
			k = KIND_PEEK;
		end else if (r < 82) begin
			k = KIND_SKIP;
			if ($urandom_range(0, 6) != 0)
				a = $urandom_range(0, u);
		end else if (r < 91) begin
			k = KIND_ADVANCE;
			if ($urandom_range(0, 6) != 0)
				a = $urandom_range(0, cap - 1 - u);
		end else if (r < 95) begin
			k = KIND_CLEAR;
		end else begin
			k = $urandom_range(0, 1) ? KIND_RSVD6 : KIND_RSVD7;
		end
		add_cmd(k, $urandom_range(0, 255), b, a);
	endfunction

	task automatic cfg_write(int val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_CAPACITY;
		pwdata <= APB_DW'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cap_reg = CAP_W'(val);
		rd_idx = 0;
		wr_idx = 0;
	endtask

	// wait until every item is sent and every result checked, then let the pipeline drain before touching the register
	task automatic settle();
		while (todo_cmds.size() != 0 || due_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			if (errors < 100)
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit fresh;
		if (!arst_n) begin
			push <= 1'b0;
			kind <= '0;
			data_byte <= '0;
			burst_length <= '0;
			move_amount <= '0;
		end else begin
			fresh = !push || !full;
			if (push && !full)
				void'(todo_cmds.pop_front());
			// a held beat stays on the bus until accepted
			if (fresh) begin
				if (todo_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					push <= 1'b1;
					kind <= todo_cmds[0].kind;
					data_byte <= todo_cmds[0].data;
					burst_length <= todo_cmds[0].burst;
					move_amount <= todo_cmds[0].amt;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (due_results.size() == 0) begin
					if (errors < 100)
						$display("%0t: unexpected beat, expected none got byte %0d used %0d",
							$time, out_byte, used_count);
					errors++;
				end else begin
					want = due_results.pop_front();
					check_field("out_byte", want.out_byte, out_byte);
					check_field("byte_valid", want.byte_valid, byte_valid);
					check_field("last", want.last, last);
					check_field("moved_count", want.moved, moved_count);
					check_field("used_count", want.used, used_count);
					check_field("free_count", want.free, free_count);
				end
			end
			pop <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int s = 0; s < NUM_SEGS; s++) begin
			if (s > 0) begin
				settle();
				cfg_write(cap_plan[s]);
				@(negedge clk);
			end
			if (s < 4) begin
				send_idle_pct = 10;
				recv_idle_pct = 76;
			end else if (s < 7) begin
				send_idle_pct = 76;
				recv_idle_pct = 10;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (s == 0) begin
				add_cmd(KIND_READ, 0, 5, 0);           // read while empty
				add_cmd(KIND_WRITE, 8'h00, 0, 0);
				add_cmd(KIND_WRITE, 8'hff, 0, 0);
				add_cmd(KIND_WRITE, 8'h5a, 0, 0);
				add_cmd(KIND_PEEK, 0, 127, 0);         // over-long burst clamps
				add_cmd(KIND_READ, 0, 0, 0);           // zero burst
				add_cmd(KIND_READ, 0, 2, 0);
				add_cmd(KIND_SKIP, 0, 0, 1);
				add_cmd(KIND_READ, 0, 64, 0);
				add_cmd(KIND_ADVANCE, 0, 0, 0);
				add_cmd(KIND_SKIP, 0, 0, 0);
				add_cmd(KIND_RSVD6, 8'h33, 9, 4095);
				add_cmd(KIND_RSVD7, 8'hcc, 120, 2048);
				add_cmd(KIND_CLEAR, 0, 0, 0);
				add_cmd(KIND_WRITE, 8'h80, 0, 0);
				add_cmd(KIND_READ, 0, 1, 0);
			end
			if (s == 1) begin
				// capacity below minimum acts as a two-slot ring
				add_cmd(KIND_WRITE, 8'h12, 0, 0);
				add_cmd(KIND_WRITE, 8'h34, 0, 0);      // dropped, ring full
				add_cmd(KIND_PEEK, 0, 1, 0);
				add_cmd(KIND_READ, 0, 64, 0);
				add_cmd(KIND_READ, 0, 3, 0);
				add_cmd(KIND_SKIP, 0, 0, 4095);        // saturates to cap - 1
				add_cmd(KIND_ADVANCE, 0, 0, 4095);
				add_cmd(KIND_CLEAR, 0, 0, 0);
			end
			repeat (RAND_PER_SEG) add_random_cmd();
		end
		settle();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#6_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
